// ===== hdl/pwlo_pkg.sv =====
// Package for the piecewise linear offset lookup.
// Holds the breakpoint curve, segment tables and datapath widths.
// No dependencies.
`default_nettype none

package pwlo_pkg;

	// Field and datapath widths.
	localparam int POS_W = 13;
	localparam int OFS_W = 11;
	localparam int ROM_POINTS = 11;
	localparam int SEG_COUNT = ROM_POINTS - 1;
	localparam int IDX_W = $clog2(SEG_COUNT);
	localparam int MAG_W = 7;
	localparam int DV_W = 10;
	localparam int M_W = DV_W + MAG_W;
	localparam int RCP_W = 18;
	localparam int RCP_SH = 24;
	localparam int Q_W = 11;
	localparam int RCP_ONE = 2 ** RCP_SH;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic signed [OFS_W-1:0] ofs_t;
	typedef logic [IDX_W-1:0] idx_t;

	// Breakpoint positions, strictly descending.
	localparam pos_t CURVE_POS [ROM_POINTS] = '{
		13'd5310, 13'd5200, 13'd5100, 13'd5000, 13'd4900, 13'd4800,
		13'd4700, 13'd4600, 13'd4500, 13'd4400, 13'd4300
	};

	// Offset value at each breakpoint.
	localparam ofs_t CURVE_VAL [ROM_POINTS] = '{
		-11'sd620, -11'sd530, -11'sd475, -11'sd390, -11'sd110, 11'sd70,
		11'sd280, 11'sd400, 11'sd470, 11'sd530, 11'sd573
	};

	// Reciprocal of each segment width, scaled by two to the RCP_SH.
	localparam logic [RCP_W-1:0] SEG_RECIP [SEG_COUNT] = '{
		RCP_W'(RCP_ONE / 110), RCP_W'(RCP_ONE / 100), RCP_W'(RCP_ONE / 100),
		RCP_W'(RCP_ONE / 100), RCP_W'(RCP_ONE / 100), RCP_W'(RCP_ONE / 100),
		RCP_W'(RCP_ONE / 100), RCP_W'(RCP_ONE / 100), RCP_W'(RCP_ONE / 100),
		RCP_W'(RCP_ONE / 100)
	};

	// Value rise across one segment, one bit wider than a value.
	function automatic logic signed [OFS_W:0] seg_dv(input idx_t k);
		logic signed [OFS_W:0] lo;
		logic signed [OFS_W:0] hi;
		lo = (OFS_W+1)'(CURVE_VAL[k]);
		hi = (OFS_W+1)'(CURVE_VAL[k + 1'b1]);
		return hi - lo;
	endfunction

	// Position width of one segment.
	function automatic logic [MAG_W-1:0] seg_den(input idx_t k);
		pos_t diff;
		diff = CURVE_POS[k] - CURVE_POS[k + 1'b1];
		return diff[MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pwlo_recip_div.sv =====
// Two-stage unsigned divide by a segment width, using a reciprocal
// multiply and one correction step. Depends on pwlo_pkg.
`default_nettype none

module pwlo_recip_div (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [pwlo_pkg::M_W-1:0] dividend,
	input  wire pwlo_pkg::idx_t        seg,
	output logic [pwlo_pkg::Q_W-1:0]   quotient
);
	import pwlo_pkg::*;

	localparam int PROD_W = M_W + RCP_W;

	logic [PROD_W-1:0] prod;
	logic [Q_W-1:0] q0_s4;
	logic [M_W-1:0] m_s4;
	idx_t seg_s4;
	logic [M_W-1:0] back;
	logic [M_W-1:0] rem;
	logic [MAG_W-1:0] den;
	logic [Q_W-1:0] q_s5;

	// The reciprocal product gives the quotient or one less.
	assign prod = PROD_W'(dividend) * PROD_W'(SEG_RECIP[seg]);

	always_ff @(posedge clk) begin
		if (en) begin
			q0_s4 <= prod[RCP_SH+Q_W-1:RCP_SH];
			m_s4 <= dividend;
			seg_s4 <= seg;
		end
	end

	// The remainder decides whether the estimate must step up by one.
	always_comb begin
		den = seg_den(seg_s4);
		back = M_W'(q0_s4 * M_W'(den));
		rem = m_s4 - back;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rem >= M_W'(den)) begin
				q_s5 <= q0_s4 + 1'b1;
			end else begin
				q_s5 <= q0_s4;
			end
		end
	end

	assign quotient = q_s5;

endmodule

`default_nettype wire

// ===== hdl/piecewise_linear_offset_interp.sv =====
// Channel   Handshake                       Payload
// input     position_valid / position_stall  position (13 bits, unsigned)
// output    offset_valid / offset_stall      offset (11 bits, signed)
//
// Six pipeline stages: segment search, distance, product, reciprocal
// multiply, correction, and the final add into the output register.
// One transaction enters per cycle unless the pipe is stalled; results leave in order.
// A stall on the output while a result waits freezes every stage, so nothing is lost or repeated.
// Reset clears only the valid bits. Depends on pwlo_pkg and pwlo_recip_div.
`default_nettype none

module piecewise_linear_offset_interp #(
	parameter int NUM_POINTS = 11
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           position_valid,
	output logic                position_stall,
	input  wire pwlo_pkg::pos_t position,
	output logic                offset_valid,
	input  wire logic           offset_stall,
	output pwlo_pkg::ofs_t      offset
);
	import pwlo_pkg::*;

	localparam int PTS_HI = (NUM_POINTS < ROM_POINTS) ? NUM_POINTS : ROM_POINTS;
	localparam int PTS_USED = (PTS_HI < 2) ? 2 : PTS_HI;
	localparam int LAST = PTS_USED - 1;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	pos_t pc;
	idx_t k;
	pos_t pc_s1;
	idx_t k_s1;

	logic [POS_W:0] d;
	logic [POS_W:0] dabs;
	logic signed [OFS_W:0] dv;
	logic [OFS_W:0] dvabs;
	logic [MAG_W-1:0] dp_s2;
	logic [DV_W-1:0] dv_s2;
	logic neg_s2;
	idx_t k_s2;

	logic [M_W-1:0] m_s3;
	logic neg_s3;
	idx_t k_s3;

	logic neg_s4, neg_s5;
	idx_t k_s4, k_s5;
	logic [Q_W-1:0] q;
	ofs_t qs;
	ofs_t offset_s6;

	// The whole pipe advances unless a finished result is held back.
	assign en = !(v_s6 && offset_stall);
	assign position_stall = v_s6 && offset_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= position_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Clamp to the curve and find the first breakpoint at or below it.
	always_comb begin
		pc = position;
		if (position > CURVE_POS[0]) begin
			pc = CURVE_POS[0];
		end else if (position < CURVE_POS[LAST]) begin
			pc = CURVE_POS[LAST];
		end
		k = IDX_W'(LAST - 1);
		for (int j = LAST - 1; j >= 0; j--) begin
			if (pc >= CURVE_POS[j]) begin
				k = IDX_W'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s1 <= pc;
			k_s1 <= k;
		end
	end

	// Signed distance from the breakpoint and the segment rise, as magnitudes.
	always_comb begin
		d = {1'b0, CURVE_POS[k_s1]} - {1'b0, pc_s1};
		dabs = d[POS_W] ? -d : d;
		dv = seg_dv(k_s1);
		dvabs = dv[OFS_W] ? -dv : dv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dp_s2 <= dabs[MAG_W-1:0];
			dv_s2 <= dvabs[DV_W-1:0];
			neg_s2 <= d[POS_W] ^ dv[OFS_W];
			k_s2 <= k_s1;
		end
	end

	// Magnitude of the numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s3 <= M_W'(dv_s2) * M_W'(dp_s2);
			neg_s3 <= neg_s2;
			k_s3 <= k_s2;
		end
	end

	// Divide by the segment width over the next two stages.
	pwlo_recip_div u_div (
		.clk      (clk),
		.en       (en),
		.dividend (m_s3),
		.seg      (k_s3),
		.quotient (q)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s4 <= neg_s3;
			k_s4 <= k_s3;
			neg_s5 <= neg_s4;
			k_s5 <= k_s4;
		end
	end

	// Apply the sign, which truncates toward zero, and add the base value.
	always_comb begin
		qs = neg_s5 ? -ofs_t'(q) : ofs_t'(q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			offset_s6 <= CURVE_VAL[k_s5] + qs;
		end
	end

	assign offset_valid = v_s6;
	assign offset = offset_s6;

endmodule

`default_nettype wire

// ===== tb/piecewise_linear_offset_interp_test.sv =====
// Self-checking testbench for the piecewise linear offset lookup.
// Drives encoder positions, predicts each offset from its own copy of the curve,
// and checks results in order. Depends on pwlo_pkg and piecewise_linear_offset_interp.
`timescale 1ns / 1ps

module piecewise_linear_offset_interp_test;
	import pwlo_pkg::*;

	localparam int CURVE_POINTS = 11;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 540;

	// Breakpoint curve, descending positions.
	localparam int BP_POS [CURVE_POINTS] = '{
		5310, 5200, 5100, 5000, 4900, 4800, 4700, 4600, 4500, 4400, 4300
	};
	localparam int BP_VAL [CURVE_POINTS] = '{
		-620, -530, -475, -390, -110, 70, 280, 400, 470, 530, 573
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic position_valid = 1'b0;
	logic position_stall;
	pos_t position = '0;
	logic offset_valid;
	logic offset_stall = 1'b0;
	ofs_t offset;

	pos_t pending_positions [$];
	ofs_t expected_offsets [$];
	logic position_taken = 1'b0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cycle_count = 0;
	int error_count = 0;
	int checked_count = 0;
	int clamped_count = 0;
	ofs_t oldest_offset;

	piecewise_linear_offset_interp DUT (
		.clk(clk),
		.arst_n(arst_n),
		.position_valid(position_valid),
		.position_stall(position_stall),
		.position(position),
		.offset_valid(offset_valid),
		.offset_stall(offset_stall),
		.offset(offset)
	);

	always #6 clk = ~clk;

	// Clamp, pick the segment, and interpolate with truncating division.
	function automatic ofs_t expected_offset(input pos_t raw);
		int p;
		int seg;
		int rise;
		int span;
		p = raw;
		if (p > BP_POS[0])
			p = BP_POS[0];
		if (p < BP_POS[CURVE_POINTS-1])
			p = BP_POS[CURVE_POINTS-1];
		seg = CURVE_POINTS - 1;
		for (int j = CURVE_POINTS - 1; j >= 0; j--)
			if (p >= BP_POS[j])
				seg = j;
		if (seg > CURVE_POINTS - 2)
			seg = CURVE_POINTS - 2;
		rise = BP_VAL[seg+1] - BP_VAL[seg];
		span = BP_POS[seg] - BP_POS[seg+1];
		if (span <= 0)
			return ofs_t'(BP_VAL[seg]);
		return ofs_t'(BP_VAL[seg] + rise * (BP_POS[seg] - p) / span);
	endfunction

	// Random position, weighted toward the curve and its edges.
	function automatic pos_t random_position();
		int pick;
		pick = $urandom_range(9);
		if (pick < 6)
			return pos_t'($urandom_range(5360, 4250));
		else if (pick < 8)
			return pos_t'(BP_POS[$urandom_range(CURVE_POINTS-1)] + $urandom_range(2) - 1);
		return pos_t'($urandom);
	endfunction

	// Driver: a new transaction is offered only once the last one was taken.
	always @(negedge clk) begin
		offset_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
		if (arst_n && (!position_valid || position_taken)) begin
			if (pending_positions.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				position_valid <= 1'b1;
				position <= pending_positions.pop_front();
			end else begin
				position_valid <= 1'b0;
				position <= pos_t'($urandom);
			end
		end
	end

	// Monitor: record accepted positions and check each accepted offset.
	always @(posedge clk) begin
		position_taken <= position_valid && !position_stall;
		if (arst_n && position_valid && !position_stall) begin
			expected_offsets.push_back(expected_offset(position));
			if (position > BP_POS[0] || position < BP_POS[CURVE_POINTS-1])
				clamped_count++;
		end
		if (arst_n && offset_valid && !offset_stall) begin
			if (expected_offsets.size() == 0) begin
				error_count++;
				$display("%0t: unexpected offset transaction, actual %0d", $time, offset);
			end else begin
				oldest_offset = expected_offsets.pop_front();
				checked_count++;
				if (offset !== oldest_offset) begin
					error_count++;
					$display("%0t: offset mismatch, expected %0d, actual %0d",
						$time, oldest_offset, offset);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stimulus in three handshake-pressure phases, then drain and report.
	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: range ends, out-of-range clamps, every breakpoint, midpoints.
		pending_positions.push_back(13'd0);
		pending_positions.push_back(13'h1FFF);
		pending_positions.push_back(13'd5311);
		pending_positions.push_back(13'd5309);
		pending_positions.push_back(13'd4299);
		pending_positions.push_back(13'd4301);
		for (int j = 0; j < CURVE_POINTS; j++)
			pending_positions.push_back(pos_t'(BP_POS[j]));
		pending_positions.push_back(13'd5255);
		pending_positions.push_back(13'd5150);
		pending_positions.push_back(13'd4850);
		pending_positions.push_back(13'd4450);
		pending_positions.push_back(13'h1555);
		pending_positions.push_back(13'h0AAA);

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 62 : 0;
			rx_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 33 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				pending_positions.push_back(random_position());
			while (pending_positions.size() > 0 || position_valid)
				@(negedge clk);
		end

		while (expected_offsets.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d offsets under three stall and gap mixes;", checked_count);
		$display("%0d positions fell outside the curve and were clamped.", clamped_count);
		if (error_count == 0 && expected_offsets.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== piecewise_linear_offset_interp.f =====
hdl/pwlo_pkg.sv
hdl/pwlo_recip_div.sv
hdl/piecewise_linear_offset_interp.sv
tb/piecewise_linear_offset_interp_test.sv
